// ===== src/mec_pkg.sv =====
package mec_pkg;

  localparam int NUM_CH = 16;
  localparam int CH_W = 4;
  localparam int COUNT_W = 16;
  localparam int TIME_W = 32;
  localparam int MIN_W = 27;
  localparam int SEC_W = 6;
  localparam int HOUR_W = 5;
  localparam int CHCNT_W = 5;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 3;

  // Division by 60 is a shift by two followed by an exact reciprocal divide by 15.
  localparam logic [31:0] DIV15_MAGIC = 32'h8888_8889;
  localparam int DIV15_SHIFT = 35;
  localparam int PROD_W = 62;

  localparam logic [CFG_IDX_W-1:0] CFG_COLLECT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHCOUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RISING = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLING = 3'd5;

  typedef enum logic [1:0] {
    KIND_EDGE = 2'd0,
    KIND_HOUR = 2'd1,
    KIND_DAY = 2'd2
  } kind_t;

  typedef struct packed {
    logic load;
    logic count_en;
    logic hour_clear;
    logic day_clear;
    logic [TIME_W-1:0] now;
  } lane_ctrl_t;

  typedef struct packed {
    logic hour_req;
    logic day_req;
    logic edge_req;
  } lane_flags_t;

  typedef struct packed {
    logic [COUNT_W-1:0] hour_total;
    logic [COUNT_W-1:0] day_total;
    logic level;
    logic [TIME_W-1:0] elapsed;
  } lane_rpt_t;

  typedef struct packed {
    logic valid;
    kind_t kind;
    logic [CH_W-1:0] channel;
    logic level;
    logic [TIME_W-1:0] elapsed;
    logic [COUNT_W-1:0] count;
    logic [HOUR_W-1:0] hour_label;
    logic last;
  } pick_t;

endpackage

// ===== src/mec_lane.sv =====
module mec_lane (
  input  logic                  clk,
  input  logic                  rst,
  input  mec_pkg::lane_ctrl_t   ctrl,
  input  logic                  active,
  input  logic                  level_in,
  input  logic                  rise_en,
  input  logic                  fall_en,
  output mec_pkg::lane_flags_t  flags,
  output mec_pkg::lane_rpt_t    rpt
);

  logic                           prev_level;
  logic [mec_pkg::TIME_W-1:0]     last_time;
  logic [mec_pkg::COUNT_W-1:0]    hour_count;
  logic [mec_pkg::COUNT_W-1:0]    day_count;
  logic [mec_pkg::COUNT_W-1:0]    hour_base;
  logic [mec_pkg::COUNT_W-1:0]    day_base;
  logic [mec_pkg::COUNT_W-1:0]    hour_count_next;
  logic [mec_pkg::COUNT_W-1:0]    day_count_next;
  logic                           edge_hit;

  function automatic logic [mec_pkg::COUNT_W-1:0] bump(input logic [mec_pkg::COUNT_W-1:0] c);
    bump = (c == '1) ? c : c + mec_pkg::COUNT_W'(1);
  endfunction

  always_comb begin
    edge_hit = active && (level_in != prev_level) && (level_in ? rise_en : fall_en);
    flags.hour_req = active && ctrl.hour_clear;
    flags.day_req = active && ctrl.day_clear;
    flags.edge_req = edge_hit;
    hour_base = flags.hour_req ? '0 : hour_count;
    day_base = flags.day_req ? '0 : day_count;
    hour_count_next = (edge_hit && ctrl.count_en) ? bump(hour_base) : hour_base;
    day_count_next = (edge_hit && ctrl.count_en) ? bump(day_base) : day_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level <= 1'b0;
      last_time <= '0;
      hour_count <= '0;
      day_count <= '0;
    end else if (ctrl.load) begin
      if (active) begin
        prev_level <= level_in;
      end
      if (edge_hit) begin
        last_time <= ctrl.now;
      end
      hour_count <= hour_count_next;
      day_count <= day_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rpt.hour_total <= hour_count;
      rpt.day_total <= day_count;
      rpt.level <= level_in;
      rpt.elapsed <= ctrl.now - last_time;
    end
  end

endmodule

// ===== src/mec_merge.sv =====
module mec_merge (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic                        advance,
  input  logic [mec_pkg::HOUR_W-1:0]  hour_label_in,
  input  mec_pkg::lane_flags_t        flags [mec_pkg::NUM_CH],
  input  mec_pkg::lane_rpt_t          rpts [mec_pkg::NUM_CH],
  output mec_pkg::pick_t              pick,
  output logic                        busy
);

  logic [mec_pkg::NUM_CH-1:0]  hour_pend;
  logic [mec_pkg::NUM_CH-1:0]  day_pend;
  logic [mec_pkg::NUM_CH-1:0]  edge_pend;
  logic [mec_pkg::HOUR_W-1:0]  hour_label;
  logic [mec_pkg::NUM_CH-1:0]  sel;
  logic [mec_pkg::NUM_CH-1:0]  sel_bit;
  logic [mec_pkg::CH_W-1:0]    idx;
  mec_pkg::kind_t              sel_kind;
  logic                        any;
  logic                        last_pick;
  logic [mec_pkg::NUM_CH-1:0]  hour_pend_next;
  logic [mec_pkg::NUM_CH-1:0]  day_pend_next;
  logic [mec_pkg::NUM_CH-1:0]  edge_pend_next;

  always_comb begin
    if (hour_pend != '0) begin
      sel = hour_pend;
      sel_kind = mec_pkg::KIND_HOUR;
    end else if (day_pend != '0) begin
      sel = day_pend;
      sel_kind = mec_pkg::KIND_DAY;
    end else begin
      sel = edge_pend;
      sel_kind = mec_pkg::KIND_EDGE;
    end
    idx = '0;
    for (int i = mec_pkg::NUM_CH - 1; i >= 0; i--) begin
      if (sel[i]) begin
        idx = mec_pkg::CH_W'(i);
      end
    end
    any = (sel != '0);
    sel_bit = '0;
    sel_bit[idx] = any;
    hour_pend_next = hour_pend;
    day_pend_next = day_pend;
    edge_pend_next = edge_pend;
    case (sel_kind)
      mec_pkg::KIND_HOUR: hour_pend_next = hour_pend & ~sel_bit;
      mec_pkg::KIND_DAY: day_pend_next = day_pend & ~sel_bit;
      default: edge_pend_next = edge_pend & ~sel_bit;
    endcase
    last_pick = (hour_pend_next == '0) && (day_pend_next == '0) && (edge_pend_next == '0);
    busy = (hour_pend != '0) || (day_pend != '0) || (edge_pend != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_pend <= '0;
      day_pend <= '0;
      edge_pend <= '0;
      pick.valid <= 1'b0;
    end else begin
      if (load) begin
        for (int i = 0; i < mec_pkg::NUM_CH; i++) begin
          hour_pend[i] <= flags[i].hour_req;
          day_pend[i] <= flags[i].day_req;
          edge_pend[i] <= flags[i].edge_req;
        end
      end else if (advance) begin
        hour_pend <= hour_pend_next;
        day_pend <= day_pend_next;
        edge_pend <= edge_pend_next;
      end
      if (advance) begin
        pick.valid <= any;
      end
    end
    if (load) begin
      hour_label <= hour_label_in;
    end
    if (advance) begin
      pick.kind <= sel_kind;
      pick.channel <= idx;
      pick.last <= last_pick;
      pick.level <= (sel_kind == mec_pkg::KIND_EDGE) ? rpts[idx].level : 1'b0;
      pick.elapsed <= (sel_kind == mec_pkg::KIND_EDGE) ? rpts[idx].elapsed : '0;
      case (sel_kind)
        mec_pkg::KIND_HOUR: pick.count <= rpts[idx].hour_total;
        mec_pkg::KIND_DAY: pick.count <= rpts[idx].day_total;
        default: pick.count <= '0;
      endcase
      pick.hour_label <= (sel_kind == mec_pkg::KIND_HOUR) ? hour_label : '0;
    end
  end

endmodule

// ===== src/mec_out.sv =====
module mec_out (
  input  logic                        clk,
  input  logic                        rst,
  input  mec_pkg::pick_t              pick,
  output logic                        advance,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  kind,
  output logic [mec_pkg::CH_W-1:0]    channel,
  output logic                        new_level,
  output logic [mec_pkg::MIN_W-1:0]   elapsed_minutes,
  output logic [mec_pkg::SEC_W-1:0]   elapsed_seconds,
  output logic [mec_pkg::COUNT_W-1:0] count,
  output logic [mec_pkg::HOUR_W-1:0]  hour_label,
  output logic                        last
);

  mec_pkg::pick_t               s1;
  logic [mec_pkg::PROD_W-1:0]   prod;
  logic [mec_pkg::MIN_W-1:0]    quot;
  logic [mec_pkg::TIME_W-1:0]   quot60;
  logic [mec_pkg::TIME_W-1:0]   rem;

  assign advance = !out_valid || !out_stall;

  always_comb begin
    quot = prod[mec_pkg::PROD_W-1:mec_pkg::DIV15_SHIFT];
    quot60 = (mec_pkg::TIME_W'(quot) << 6) - (mec_pkg::TIME_W'(quot) << 2);
    rem = s1.elapsed - quot60;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1.valid <= pick.valid;
      out_valid <= s1.valid;
    end
    if (advance) begin
      s1.kind <= pick.kind;
      s1.channel <= pick.channel;
      s1.level <= pick.level;
      s1.elapsed <= pick.elapsed;
      s1.count <= pick.count;
      s1.hour_label <= pick.hour_label;
      s1.last <= pick.last;
      prod <= mec_pkg::PROD_W'(pick.elapsed[mec_pkg::TIME_W-1:2])
              * mec_pkg::PROD_W'(mec_pkg::DIV15_MAGIC);
      kind <= s1.kind;
      channel <= s1.channel;
      new_level <= s1.level;
      elapsed_minutes <= quot;
      elapsed_seconds <= rem[mec_pkg::SEC_W-1:0];
      count <= s1.count;
      hour_label <= s1.hour_label;
      last <= s1.last;
    end
  end

endmodule

// ===== src/multichannel_edge_event_counter.sv =====
// Channel   Handshake             Payload
// in        in_valid / in_stall   now_seconds, hour_of_day, hour_rollover, day_rollover,
//                                 point_levels
// out       out_valid / out_stall kind, channel, new_level, elapsed_minutes,
//                                 elapsed_seconds, count, hour_label, last
// cfg       cfg_we                cfg_index, cfg_data
//
// A tick is taken and the sixteen lanes update their state at once.
// The picker then issues one result per cycle unless the output stalls, so a tick that
// causes k results, at most 48, holds off the next request until all are issued.
// Each result passes a divide-by-60 multiply stage and then the output register.
// Reset at once clears lane counts and config but sets edge masks; no clearing pass.
// A stall on the output freezes the whole result pipeline and the picker.
module multichannel_edge_event_counter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mec_pkg::TIME_W-1:0]    now_seconds,
  input  logic [mec_pkg::HOUR_W-1:0]    hour_of_day,
  input  logic                          hour_rollover,
  input  logic                          day_rollover,
  input  logic [mec_pkg::NUM_CH-1:0]    point_levels,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    kind,
  output logic [mec_pkg::CH_W-1:0]      channel,
  output logic                          new_level,
  output logic [mec_pkg::MIN_W-1:0]     elapsed_minutes,
  output logic [mec_pkg::SEC_W-1:0]     elapsed_seconds,
  output logic [mec_pkg::COUNT_W-1:0]   count,
  output logic [mec_pkg::HOUR_W-1:0]    hour_label,
  output logic                          last,
  input  logic                          cfg_we,
  input  logic [mec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mec_pkg::CFG_W-1:0]     cfg_data
);

  logic                          collect_enable;
  logic                          count_enable;
  logic [mec_pkg::CHCNT_W-1:0]   channel_count;
  logic [mec_pkg::NUM_CH-1:0]    channel_valid_mask;
  logic [mec_pkg::NUM_CH-1:0]    rising_mask;
  logic [mec_pkg::NUM_CH-1:0]    falling_mask;
  logic [mec_pkg::HOUR_W-1:0]    previous_hour;
  logic [mec_pkg::NUM_CH-1:0]    lane_active;
  logic                          busy;
  logic                          load;
  logic                          advance;
  mec_pkg::lane_ctrl_t           ctrl;
  mec_pkg::lane_flags_t          flags [mec_pkg::NUM_CH];
  mec_pkg::lane_rpt_t            rpts [mec_pkg::NUM_CH];
  mec_pkg::pick_t                pick;

  assign in_stall = busy;
  assign load = in_valid && !in_stall && collect_enable;

  always_comb begin
    for (int i = 0; i < mec_pkg::NUM_CH; i++) begin
      lane_active[i] = channel_valid_mask[i] && (mec_pkg::CHCNT_W'(i) < channel_count);
    end
    ctrl.load = load;
    ctrl.count_en = count_enable;
    ctrl.hour_clear = count_enable && hour_rollover;
    ctrl.day_clear = count_enable && day_rollover;
    ctrl.now = now_seconds;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collect_enable <= 1'b0;
      count_enable <= 1'b0;
      channel_count <= '0;
      channel_valid_mask <= '0;
      rising_mask <= '1;
      falling_mask <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mec_pkg::CFG_COLLECT: collect_enable <= cfg_data[0];
        mec_pkg::CFG_COUNT: count_enable <= cfg_data[0];
        mec_pkg::CFG_CHCOUNT: channel_count <= cfg_data[mec_pkg::CHCNT_W-1:0];
        mec_pkg::CFG_VALID: channel_valid_mask <= cfg_data[mec_pkg::NUM_CH-1:0];
        mec_pkg::CFG_RISING: rising_mask <= cfg_data[mec_pkg::NUM_CH-1:0];
        mec_pkg::CFG_FALLING: falling_mask <= cfg_data[mec_pkg::NUM_CH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_hour <= '0;
    end else if (load) begin
      previous_hour <= hour_of_day;
    end
  end

  for (genvar g = 0; g < mec_pkg::NUM_CH; g++) begin : g_lane
    mec_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .active   (lane_active[g]),
      .level_in (point_levels[g]),
      .rise_en  (rising_mask[g]),
      .fall_en  (falling_mask[g]),
      .flags    (flags[g]),
      .rpt      (rpts[g])
    );
  end

  mec_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .advance       (advance),
    .hour_label_in (previous_hour),
    .flags         (flags),
    .rpts          (rpts),
    .pick          (pick),
    .busy          (busy)
  );

  mec_out u_out (
    .clk             (clk),
    .rst             (rst),
    .pick            (pick),
    .advance         (advance),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .channel         (channel),
    .new_level       (new_level),
    .elapsed_minutes (elapsed_minutes),
    .elapsed_seconds (elapsed_seconds),
    .count           (count),
    .hour_label      (hour_label),
    .last            (last)
  );

endmodule
